// ----- design/binary_log_record_parser_defines.svh -----
// assertion macros used by the binary log record parser datapath
`ifndef BINARY_LOG_RECORD_PARSER_DEFINES_SVH
`define BINARY_LOG_RECORD_PARSER_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define BLRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define BLRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/blrp_pkg.sv -----
// types and constants of the binary log record parser
package blrp_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int ALIGN_DEF    = 4;

    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 104;

    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLED    = 2'd2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_UNSUP = 2'd2;

    localparam logic [1:0] SEL_COUNTED = 2'd0;
    localparam logic [1:0] SEL_NOSTAMP = 2'd1;
    localparam logic [1:0] SEL_STAMP16 = 2'd2;
    localparam logic [1:0] SEL_STAMP32 = 2'd3;

    localparam logic [1:0] SW_COUNTED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] id;
        logic [1:0]  sw;
        logic [31:0] stamp;
        logic [14:0] plen;
        logic [7:0]  cyc;
        logic [7:0]  pbyte;
        logic        lir;
        logic [1:0]  err;
        logic [15:0] cons;
    } res_t;

    // commands from the controller, all zero unless a byte is taken
    typedef struct packed {
        logic       ld_w0;
        logic       ld_w1;
        logic       ld_stamp;
        logic       ld_count;
        logic       bif_inc;
        logic       bif_clr;
        logic       pos_inc;
        logic       pos_pad;
        logic       buf_clr;
        logic       hold_push;
        logic       hc_clr;
        logic       replay;
        logic       pl_load;
        logic       pl_dec;
        logic       emit_hdr;
        logic       emit_pay;
        logic       emit_tail;
        logic [1:0] tail_kind;
        logic [1:0] tail_err;
    } cmd_t;

    typedef struct packed {
        logic       go;
        logic       last;
        logic       bzero;
        logic [1:0] sel;
        logic       plen_zero;
        logic       pay_zero;
        logic       skip_done;
        logic       stamp_done;
        logic       count_done;
        logic       pad_fill;
        logic       pad_short;
        logic       need_nz;
        logic       counted_en;
        logic       doubled;
    } sts_t;

endpackage

// ----- design/blrp_ctrl.sv -----
// record parsing state machine of the binary log record parser
module blrp_ctrl
    import blrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_W0      = 8'b0000_0001,
        ST_W1      = 8'b0000_0010,
        ST_SKIP    = 8'b0000_0100,
        ST_STAMP   = 8'b0000_1000,
        ST_COUNT   = 8'b0001_0000,
        ST_PAYLOAD = 8'b0010_0000,
        ST_PAD     = 8'b0100_0000,
        ST_ERR     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_W0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        logic rec_done;
        logic chk_short;
        cmd        = '0;
        state_next = state_reg;
        rec_done   = 1'b0;
        chk_short  = 1'b0;
        if (sts.go)
        begin
            unique case (state_reg)
                ST_ERR:
                begin
                    // rest of a failed buffer is dropped
                    if (sts.last)
                    begin
                        cmd.buf_clr = 1'b1;
                        state_next  = ST_W0;
                    end
                end
                ST_PAD:
                begin
                    if (!sts.bzero || (sts.pad_short && sts.last))
                    begin
                        // not padding after all: parse held bytes again
                        cmd.replay  = 1'b1;
                        cmd.bif_clr = 1'b1;
                        state_next  = ST_W0;
                    end
                    else if (sts.pad_fill)
                    begin
                        cmd.pos_pad = 1'b1;
                        cmd.hc_clr  = 1'b1;
                        state_next  = ST_W0;
                        if (sts.last)
                        begin
                            cmd.emit_tail = 1'b1;
                            cmd.tail_kind = KIND_DONE;
                            cmd.buf_clr   = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.hold_push = 1'b1;
                    end
                end
                ST_W0:
                begin
                    cmd.pos_inc = 1'b1;
                    cmd.ld_w0   = 1'b1;
                    chk_short   = 1'b1;
                    state_next  = ST_W1;
                end
                ST_W1:
                begin
                    cmd.pos_inc = 1'b1;
                    cmd.ld_w1   = 1'b1;
                    cmd.bif_clr = 1'b1;
                    chk_short   = 1'b1;
                    case (sts.sel)
                        SEL_COUNTED:
                        begin
                            if (!sts.counted_en)
                            begin
                                cmd.emit_tail = 1'b1;
                                cmd.tail_kind = KIND_ERROR;
                                cmd.tail_err  = ERR_UNSUP;
                                chk_short     = 1'b0;
                                if (sts.last)
                                begin
                                    cmd.buf_clr = 1'b1;
                                    state_next  = ST_W0;
                                end
                                else
                                begin
                                    state_next = ST_ERR;
                                end
                            end
                            else
                            begin
                                cmd.pl_load  = 1'b1;
                                cmd.emit_hdr = 1'b1;
                                if (sts.plen_zero)
                                begin
                                    rec_done = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_PAYLOAD;
                                end
                            end
                        end
                        SEL_NOSTAMP: state_next = ST_COUNT;
                        SEL_STAMP16: state_next = sts.doubled ? ST_SKIP : ST_STAMP;
                        default:     state_next = ST_STAMP;
                    endcase
                end
                ST_SKIP:
                begin
                    cmd.pos_inc = 1'b1;
                    chk_short   = 1'b1;
                    if (sts.skip_done)
                    begin
                        cmd.bif_clr = 1'b1;
                        state_next  = ST_STAMP;
                    end
                    else
                    begin
                        cmd.bif_inc = 1'b1;
                    end
                end
                ST_STAMP:
                begin
                    cmd.pos_inc  = 1'b1;
                    cmd.ld_stamp = 1'b1;
                    chk_short    = 1'b1;
                    if (sts.stamp_done)
                    begin
                        cmd.bif_clr = 1'b1;
                        state_next  = ST_COUNT;
                    end
                    else
                    begin
                        cmd.bif_inc = 1'b1;
                    end
                end
                ST_COUNT:
                begin
                    cmd.pos_inc  = 1'b1;
                    cmd.ld_count = 1'b1;
                    chk_short    = 1'b1;
                    if (sts.count_done)
                    begin
                        cmd.bif_clr  = 1'b1;
                        cmd.pl_load  = 1'b1;
                        cmd.emit_hdr = 1'b1;
                        if (sts.plen_zero)
                        begin
                            rec_done = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_PAYLOAD;
                        end
                    end
                    else
                    begin
                        cmd.bif_inc = 1'b1;
                    end
                end
                ST_PAYLOAD:
                begin
                    cmd.pos_inc  = 1'b1;
                    cmd.pl_dec   = 1'b1;
                    cmd.emit_pay = 1'b1;
                    chk_short    = 1'b1;
                    if (sts.pay_zero)
                    begin
                        rec_done = 1'b1;
                    end
                end
                default:
                begin
                    state_next = ST_W0;
                end
            endcase

            if (rec_done)
            begin
                if (sts.last)
                begin
                    cmd.emit_tail = 1'b1;
                    cmd.tail_kind = KIND_DONE;
                    cmd.buf_clr   = 1'b1;
                    state_next    = ST_W0;
                end
                else
                begin
                    cmd.hc_clr  = 1'b1;
                    cmd.bif_clr = 1'b1;
                    state_next  = sts.need_nz ? ST_PAD : ST_W0;
                end
            end
            else if (chk_short && sts.last)
            begin
                // buffer ended inside a record
                cmd.emit_tail = 1'b1;
                cmd.tail_kind = KIND_ERROR;
                cmd.tail_err  = ERR_SHORT;
                cmd.buf_clr   = 1'b1;
                state_next    = ST_W0;
            end
        end
    end

endmodule

// ----- design/blrp_datapath.sv -----
// field registers, replay queue and output stage of the binary log record parser
`include "binary_log_record_parser_defines.svh"

module blrp_datapath
    import blrp_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF,
    parameter int ALIGN_BYTES   = ALIGN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int AW = $clog2(ALIGN_BYTES);
    localparam int QD = ALIGN_BYTES + 1;
    localparam int QW = $clog2(QD + 1);
    localparam longint unsigned POS_SPAN = 64'd1 << POSITION_BITS;
    // alignment phase of the position after a wrap past the top
    localparam int WRAP_MOD = int'((longint'(ALIGN_BYTES) - longint'(POS_SPAN
        % longint'(ALIGN_BYTES))) % longint'(ALIGN_BYTES));

    logic be_reg;
    logic cfe_reg;
    logic did_reg;

    logic [15:0]              fw_reg, fw_next;
    logic [31:0]              stamp_reg, stamp_next;
    logic [15:0]              cw_reg, cw_next;
    logic [14:0]              pl_reg, pl_next;
    logic [1:0]               bif_reg, bif_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [AW-1:0]            pm_reg, pm_next;
    logic [AW-1:0]            hc_reg, hc_next;
    logic [7:0]               hold_reg [QD];
    logic [7:0]               hold_next [QD];
    logic [7:0]               q_byte_reg [QD];
    logic [7:0]               q_byte_next [QD];
    logic                     q_last_reg [QD];
    logic                     q_last_next [QD];
    logic [QW-1:0]            q_cnt_reg, q_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     pend_valid_reg, pend_valid_next;
    res_t                     out_res_reg, out_res_next;
    res_t                     pend_res_reg, pend_res_next;

    logic                     from_q;
    logic                     out_free;
    logic                     go;
    logic [7:0]               cur_byte;
    logic                     cur_last;
    logic [14:0]              hdr_plen;
    logic [7:0]               hdr_cyc;
    logic [AW:0]              need_cur;
    logic [AW:0]              hc_inc;
    logic [POSITION_BITS:0]   pad_sum;
    logic [POSITION_BITS-1:0] pos_adv;
    logic [AW-1:0]            pm_inc;
    logic [AW-1:0]            pm_adv;
    logic                     has_main;
    res_t                     main_res;
    res_t                     tail_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_reg  <= 1'b1;
            cfe_reg <= 1'b1;
            did_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_BIG_ENDIAN: be_reg  <= cfg_data;
                CFG_COUNTED:    cfe_reg <= cfg_data;
                CFG_DOUBLED:    did_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // held bytes waiting for a replay go ahead of new input
    assign from_q   = (q_cnt_reg != '0);
    assign out_free = !pend_valid_reg && (!out_valid_reg || m_tready);
    assign go       = out_free && (from_q || s_tvalid);
    assign s_tready = out_free && !from_q;
    assign cur_byte = from_q ? q_byte_reg[0] : s_tdata;
    assign cur_last = from_q ? q_last_reg[0] : s_tlast;

    always_comb
    begin
        fw_next = fw_reg;
        if (cmd.ld_w0)
        begin
            fw_next = {8'h00, cur_byte};
        end
        else if (cmd.ld_w1)
        begin
            fw_next = be_reg ? {fw_reg[7:0], cur_byte} : {cur_byte, fw_reg[7:0]};
        end

        stamp_next = stamp_reg;
        cw_next    = cw_reg;
        if (cmd.ld_w1)
        begin
            stamp_next = '0;
            cw_next    = '0;
        end
        else if (cmd.ld_stamp)
        begin
            stamp_next = be_reg ? {stamp_reg[23:0], cur_byte}
                                : stamp_reg | (32'(cur_byte) << {bif_reg, 3'b000});
        end
        else if (cmd.ld_count)
        begin
            cw_next = be_reg ? {cw_reg[7:0], cur_byte}
                             : cw_reg | (16'(cur_byte) << {bif_reg, 3'b000});
        end
    end

    // header fields follow the values this byte leaves behind
    always_comb
    begin
        if (fw_next[15:14] == SEL_COUNTED)
        begin
            hdr_plen = {1'b0, fw_next[13:0]};
            hdr_cyc  = '0;
        end
        else if (cw_next[15])
        begin
            hdr_plen = cw_next[14:0];
            hdr_cyc  = '0;
        end
        else
        begin
            hdr_plen = {7'h00, cw_next[15:8]};
            hdr_cyc  = cw_next[7:0];
        end
    end

    always_comb
    begin
        pl_next = pl_reg;
        if (cmd.pl_load)
        begin
            pl_next = hdr_plen;
        end
        else if (cmd.pl_dec && (pl_reg != '0))
        begin
            pl_next = pl_reg - 15'd1;
        end

        bif_next = bif_reg;
        if (cmd.bif_clr || cmd.buf_clr)
        begin
            bif_next = '0;
        end
        else if (cmd.bif_inc)
        begin
            bif_next = bif_reg + 2'd1;
        end
    end

    // buffer position and its phase within the alignment
    assign need_cur = (pm_reg == '0) ? '0 : (AW + 1)'(ALIGN_BYTES) - {1'b0, pm_reg};
    assign hc_inc   = {1'b0, hc_reg} + (AW + 1)'(1);
    assign pad_sum  = {1'b0, pos_reg} + (POSITION_BITS + 1)'(need_cur);
    assign pm_inc   = ((pos_reg == '1) || (pm_reg == AW'(ALIGN_BYTES - 1)))
                      ? '0 : pm_reg + AW'(1);
    assign pos_adv  = cmd.pos_pad ? pad_sum[POSITION_BITS-1:0]
                                  : pos_reg + POSITION_BITS'(1);
    assign pm_adv   = cmd.pos_pad ? (pad_sum[POSITION_BITS] ? AW'(WRAP_MOD) : '0) : pm_inc;

    always_comb
    begin
        pos_next = pos_reg;
        pm_next  = pm_reg;
        if (cmd.buf_clr)
        begin
            pos_next = '0;
            pm_next  = '0;
        end
        else if (cmd.pos_inc || cmd.pos_pad)
        begin
            pos_next = pos_adv;
            pm_next  = pm_adv;
        end
    end

    always_comb
    begin
        int rc;
        rc = int'(hc_reg) + 1 + (from_q ? int'(q_cnt_reg) - 1 : 0);
        for (int i = 0; i < QD; i++)
        begin
            hold_next[i]   = hold_reg[i];
            q_byte_next[i] = q_byte_reg[i];
            q_last_next[i] = q_last_reg[i];
        end
        q_cnt_next = q_cnt_reg;
        hc_next    = hc_reg;

        if (cmd.replay)
        begin
            // held bytes, then this byte, then what was still queued
            for (int i = 0; i < QD; i++)
            begin
                if (i < int'(hc_reg))
                begin
                    q_byte_next[i] = hold_reg[i];
                    q_last_next[i] = 1'b0;
                end
                else if (i == int'(hc_reg))
                begin
                    q_byte_next[i] = cur_byte;
                    q_last_next[i] = cur_last;
                end
                else
                begin
                    for (int k = 1; k < QD; k++)
                    begin
                        if (from_q && (k == i - int'(hc_reg)))
                        begin
                            q_byte_next[i] = q_byte_reg[k];
                            q_last_next[i] = q_last_reg[k];
                        end
                    end
                end
            end
            q_cnt_next = (rc > QD) ? QW'(QD) : QW'(rc);
        end
        else if (go && from_q)
        begin
            for (int i = 0; i < QD - 1; i++)
            begin
                q_byte_next[i] = q_byte_reg[i+1];
                q_last_next[i] = q_last_reg[i+1];
            end
            q_cnt_next = q_cnt_reg - QW'(1);
        end

        if (cmd.replay || cmd.hc_clr || cmd.buf_clr)
        begin
            hc_next = '0;
        end
        else if (cmd.hold_push)
        begin
            for (int i = 0; i < QD; i++)
            begin
                if (i == int'(hc_reg))
                begin
                    hold_next[i] = cur_byte;
                end
            end
            hc_next = hc_reg + AW'(1);
        end
    end

    always_comb
    begin
        main_res       = '0;
        main_res.kind  = cmd.emit_pay ? KIND_PAYLOAD : KIND_HEADER;
        main_res.plen  = hdr_plen;
        main_res.cyc   = hdr_cyc;
        main_res.err   = ERR_NONE;
        if (fw_next[15:14] == SEL_COUNTED)
        begin
            main_res.sw = SW_COUNTED;
        end
        else
        begin
            main_res.id    = fw_next[13:0];
            main_res.sw    = fw_next[15:14] - 2'd1;
            main_res.stamp = stamp_next;
        end
        main_res.pbyte = cmd.emit_pay ? cur_byte : '0;
        main_res.lir   = cmd.emit_pay ? (pl_next == '0) : (hdr_plen == '0);

        tail_res      = '0;
        tail_res.kind = cmd.tail_kind;
        tail_res.err  = cmd.tail_err;
        tail_res.cons = (cmd.tail_kind == KIND_DONE) ? 16'(pos_adv) : '0;
    end

    // a byte may give a header or payload result followed by a done or error result
    assign has_main = cmd.emit_hdr || cmd.emit_pay;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_res_next    = out_res_reg;
        pend_res_next   = pend_res_reg;
        if (go && (has_main || cmd.emit_tail))
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = has_main && cmd.emit_tail;
            out_res_next    = has_main ? main_res : tail_res;
            pend_res_next   = tail_res;
        end
        else if (out_valid_reg && m_tready)
        begin
            if (pend_valid_reg)
            begin
                out_res_next    = pend_res_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bif_reg        <= '0;
            pos_reg        <= '0;
            pm_reg         <= '0;
            hc_reg         <= '0;
            q_cnt_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            bif_reg        <= bif_next;
            pos_reg        <= pos_next;
            pm_reg         <= pm_next;
            hc_reg         <= hc_next;
            q_cnt_reg      <= q_cnt_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fw_reg       <= fw_next;
        stamp_reg    <= stamp_next;
        cw_reg       <= cw_next;
        pl_reg       <= pl_next;
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
        for (int i = 0; i < QD; i++)
        begin
            hold_reg[i]   <= hold_next[i];
            q_byte_reg[i] <= q_byte_next[i];
            q_last_reg[i] <= q_last_next[i];
        end
    end

    assign sts.go         = go;
    assign sts.last       = cur_last;
    assign sts.bzero      = (cur_byte == 8'h00);
    assign sts.sel        = fw_next[15:14];
    assign sts.plen_zero  = (hdr_plen == '0);
    assign sts.pay_zero   = (pl_reg <= 15'd1);
    assign sts.skip_done  = (bif_reg == 2'd1);
    assign sts.stamp_done = ({1'b0, bif_reg} + 3'd1)
                            >= ((fw_reg[15:14] == SEL_STAMP32) ? 3'd4 : 3'd2);
    assign sts.count_done = (bif_reg == 2'd1);
    assign sts.pad_fill   = (hc_inc >= need_cur);
    assign sts.pad_short  = (hc_inc < need_cur);
    assign sts.need_nz    = (pm_inc != '0);
    assign sts.counted_en = cfe_reg;
    assign sts.doubled    = did_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.lir;
    assign m_tdata  = {7'h00, out_res_reg.cons, out_res_reg.err, out_res_reg.pbyte,
                       out_res_reg.cyc, out_res_reg.plen, out_res_reg.stamp,
                       out_res_reg.sw, out_res_reg.id};

    `BLRP_ASSERT(a_pend_needs_out, pend_valid_reg |-> out_valid_reg, "second result without first")
    `BLRP_ASSERT_NEXT(a_replay_fills_queue, go && cmd.replay, q_cnt_reg != '0, "replay left queue empty")
    `BLRP_ASSERT(a_queue_bound, q_cnt_reg <= QW'(QD), "replay queue overfilled")
    `BLRP_ASSERT_NEXT(a_emit_sets_valid, go && cmd.emit_tail, m_tvalid, "result not presented")

endmodule

// ----- design/binary_log_record_parser.sv -----
// top level of the binary log record parser
//
// bytes of a decoded buffer enter on the s_ channel, tlast on the last byte of a buffer.
// the m_ channel returns header, payload byte, buffer done and error requests; tuser
// carries the kind and tlast marks the final request of a record.
// a request is registered and appears in the cycle after its byte is accepted.
// throughput: one byte per cycle unless the output stalls or a replay runs; a byte that
// causes two requests (a header or payload byte followed by buffer done or an error)
// holds the input while the second waits in the second slot.
// when non-zero padding turns out to start the next record, the held bytes (at most
// ALIGN_BYTES-2 plus the current one) are parsed again from an internal queue, one per
// cycle while the output is free, with s_tready low meanwhile.
// the output register holds one request and a second slot takes the extra request of a
// byte; while m_tready is low a full output register keeps the input stalled.
// reset clears the parse state, position count and queue; registers return to big endian,
// counted frames on, no doubled id. write configuration only while idle; not enforced.
module binary_log_record_parser
    import blrp_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF,
    parameter int ALIGN_BYTES   = ALIGN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // data_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // record_id, stamp_width, stamp_value, payload_length, cycle_count, payload_byte,
    // error_code, consumed_bytes, zero fill
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [1:0]           m_tuser,    // record_kind
    output logic                 m_tlast,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    cmd_t cmd;
    sts_t sts;

    blrp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    blrp_datapath #(
        .POSITION_BITS (POSITION_BITS),
        .ALIGN_BYTES   (ALIGN_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- bench/record_stream_checker.sv -----
// checker for the binary log record parser: predicts every output request and compares
`timescale 1ns / 100ps

module record_stream_checker
    import blrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,    // data_byte
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // record_id, stamp_width, stamp_value, payload_length, cycle_count, payload_byte,
    // error_code, consumed_bytes, zero fill
    input  logic [TDATA_W-1:0]   m_tdata,
    input  logic [1:0]           m_tuser,    // record_kind
    input  logic                 m_tlast,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_seen
);

    localparam int ALIGN        = ALIGN_DEF;
    localparam int MAX_PER_BYTE = 8;

    typedef enum logic [6:0] {
        ST_HDR0    = 7'b000_0001,
        ST_HDR1    = 7'b000_0010,
        ST_SKIP    = 7'b000_0100,
        ST_STAMP   = 7'b000_1000,
        ST_COUNT   = 7'b001_0000,
        ST_PAYLOAD = 7'b010_0000,
        ST_PAD     = 7'b100_0000
    } parse_state_t;

    bit                      be_cfg;
    bit                      counted_cfg;
    bit                      doubled_cfg;
    parse_state_t            state;
    int unsigned             field_idx;
    logic [15:0]             first_word;
    logic [31:0]             stamp_acc;
    logic [15:0]             count_acc;
    logic [14:0]             left;
    logic [POS_BITS_DEF-1:0] pos;
    logic [7:0]              held [ALIGN];
    int unsigned             held_n;
    bit                      err_latched;
    int                      step_n;

    res_t                    predicted_results[$];
    logic [8:0]              replay_stack[$];

    task automatic report(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want)
            report($sformatf("request %0d: %s is %0h, predicted %0h",
                             results_seen, name, got, want));
    endtask

    function automatic logic [31:0] shift_in(input logic [31:0] old, input logic [7:0] b,
                                             input int unsigned k);
        if (be_cfg)
            return {old[23:0], b};
        return old | (32'(b) << (8 * (k % 4)));
    endfunction

    function automatic int unsigned pad_need();
        return (ALIGN - pos % ALIGN) % ALIGN;
    endfunction

    task automatic queue_result(input logic [1:0] kind, input bit hdr, input logic [7:0] pb,
                                input bit lir, input logic [1:0] code,
                                input logic [15:0] cons);
        res_t        r;
        logic [1:0]  sel;
        if (step_n >= MAX_PER_BYTE)
            return;
        r = '0;
        sel = first_word[15:14];
        r.kind = kind;
        if (hdr)
        begin
            if (sel == SEL_COUNTED)
            begin
                r.sw = SW_COUNTED;
                r.plen = 15'(first_word[13:0]);
            end
            else
            begin
                r.id = first_word[13:0];
                r.sw = sel - 2'd1;
                r.stamp = stamp_acc;
                if (count_acc[15])
                    r.plen = count_acc[14:0];
                else
                begin
                    r.plen = 15'(count_acc[15:8]);
                    r.cyc = count_acc[7:0];
                end
            end
        end
        r.pbyte = pb;
        r.lir = lir;
        r.err = code;
        r.cons = cons;
        predicted_results.push_back(r);
        step_n++;
    endtask

    task automatic clear_buffer();
        state = ST_HDR0;
        field_idx = 0;
        pos = '0;
        held_n = 0;
        err_latched = 0;
    endtask

    task automatic push_replay(input logic [7:0] b, input bit last);
        if (replay_stack.size() < ALIGN + 1)
            replay_stack.push_back({last, b});
    endtask

    task automatic raise_error(input logic [1:0] code, input bit last);
        queue_result(KIND_ERROR, 0, 8'd0, 0, code, 16'd0);
        if (last)
            clear_buffer();
        else
            err_latched = 1;
    endtask

    task automatic record_done(input bit last);
        if (last)
        begin
            queue_result(KIND_DONE, 0, 8'd0, 0, ERR_NONE, 16'(pos));
            clear_buffer();
        end
        else
        begin
            held_n = 0;
            field_idx = 0;
            state = (pad_need() != 0) ? ST_PAD : ST_HDR0;
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input bit last);
        bit          done;
        int unsigned need;
        int          n;
        int          i;
        done = 0;
        if (err_latched)
        begin
            if (last)
                clear_buffer();
            return;
        end
        if (state == ST_PAD)
        begin
            if (held_n < ALIGN)
            begin
                held[held_n] = b;
                held_n++;
            end
            need = pad_need();
            // a non-zero byte, or a buffer ending mid-padding, turns the held bytes into a header
            if (b != 8'd0 || (held_n < need && last))
            begin
                state = ST_HDR0;
                field_idx = 0;
                n = held_n;
                held_n = 0;
                for (i = n; i > 0; i--)
                    push_replay(held[i-1], (i == n) ? last : 1'b0);
                return;
            end
            if (held_n >= need)
            begin
                pos = pos + POS_BITS_DEF'(need);
                held_n = 0;
                state = ST_HDR0;
                if (last)
                begin
                    queue_result(KIND_DONE, 0, 8'd0, 0, ERR_NONE, 16'(pos));
                    clear_buffer();
                end
            end
            return;
        end
        pos = pos + POS_BITS_DEF'(1);
        case (state)
            ST_HDR0:
            begin
                first_word = {8'd0, b};
                state = ST_HDR1;
            end
            ST_HDR1:
            begin
                first_word = 16'(shift_in(32'(first_word), b, 1));
                stamp_acc = '0;
                count_acc = '0;
                field_idx = 0;
                case (first_word[15:14])
                    SEL_COUNTED:
                    begin
                        if (!counted_cfg)
                        begin
                            raise_error(ERR_UNSUP, last);
                            return;
                        end
                        left = 15'(first_word[13:0]);
                        queue_result(KIND_HEADER, 1, 8'd0, left == 0, ERR_NONE, 16'd0);
                        if (left == 0)
                            done = 1;
                        else
                            state = ST_PAYLOAD;
                    end
                    SEL_NOSTAMP: state = ST_COUNT;
                    SEL_STAMP16: state = doubled_cfg ? ST_SKIP : ST_STAMP;
                    default:     state = ST_STAMP;
                endcase
            end
            ST_SKIP:
            begin
                field_idx++;
                if (field_idx >= 2)
                begin
                    field_idx = 0;
                    state = ST_STAMP;
                end
            end
            ST_STAMP:
            begin
                stamp_acc = shift_in(stamp_acc, b, field_idx);
                field_idx++;
                if (field_idx >= ((first_word[15:14] == SEL_STAMP32) ? 4 : 2))
                begin
                    field_idx = 0;
                    state = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                count_acc = 16'(shift_in(32'(count_acc), b, field_idx));
                field_idx++;
                if (field_idx >= 2)
                begin
                    field_idx = 0;
                    left = count_acc[15] ? count_acc[14:0] : 15'(count_acc[15:8]);
                    queue_result(KIND_HEADER, 1, 8'd0, left == 0, ERR_NONE, 16'd0);
                    if (left == 0)
                        done = 1;
                    else
                        state = ST_PAYLOAD;
                end
            end
            default:
            begin
                if (left > 0)
                    left--;
                queue_result(KIND_PAYLOAD, 1, b, left == 0, ERR_NONE, 16'd0);
                if (left == 0)
                    done = 1;
            end
        endcase
        if (done)
            record_done(last);
        else if (last)
            raise_error(ERR_SHORT, 1);
    endtask

    task automatic predict_byte(input logic [7:0] b, input bit last);
        logic [8:0] item;
        step_n = 0;
        replay_stack.delete();
        push_replay(b, last);
        while (replay_stack.size() > 0)
        begin
            item = replay_stack.pop_back();
            take_byte(item[7:0], item[8]);
        end
    endtask

    task automatic check_result();
        res_t got;
        res_t want;
        results_seen++;
        got.kind  = m_tuser;
        got.id    = m_tdata[13:0];
        got.sw    = m_tdata[15:14];
        got.stamp = m_tdata[47:16];
        got.plen  = m_tdata[62:48];
        got.cyc   = m_tdata[70:63];
        got.pbyte = m_tdata[78:71];
        got.err   = m_tdata[80:79];
        got.cons  = m_tdata[96:81];
        got.lir   = m_tlast;
        cmp_field("fill bits", 32'(m_tdata[TDATA_W-1:97]), 32'd0);
        if (predicted_results.size() == 0)
        begin
            report($sformatf("request %0d arrived with none predicted", results_seen));
            return;
        end
        want = predicted_results.pop_front();
        cmp_field("record_kind", 32'(got.kind), 32'(want.kind));
        cmp_field("record_id", 32'(got.id), 32'(want.id));
        cmp_field("stamp_width", 32'(got.sw), 32'(want.sw));
        cmp_field("stamp_value", got.stamp, want.stamp);
        cmp_field("payload_length", 32'(got.plen), 32'(want.plen));
        cmp_field("cycle_count", 32'(got.cyc), 32'(want.cyc));
        cmp_field("payload_byte", 32'(got.pbyte), 32'(want.pbyte));
        cmp_field("last_in_record", 32'(got.lir), 32'(want.lir));
        cmp_field("error_code", 32'(got.err), 32'(want.err));
        cmp_field("consumed_bytes", 32'(got.cons), 32'(want.cons));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_cfg = 1;
            counted_cfg = 1;
            doubled_cfg = 0;
            first_word = '0;
            stamp_acc = '0;
            count_acc = '0;
            left = '0;
            for (int k = 0; k < ALIGN; k++)
                held[k] = 8'd0;
            clear_buffer();
            predicted_results.delete();
            mismatches = 0;
            results_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_BIG_ENDIAN: be_cfg = cfg_data;
                    CFG_COUNTED:    counted_cfg = cfg_data;
                    CFG_DOUBLED:    doubled_cfg = cfg_data;
                    default:        ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            outstanding <= predicted_results.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// top of the binary log record parser bench: clock, reset, byte buffers, back-pressure, verdict
`timescale 1ns / 100ps

module tb_top;
    import blrp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_BYTES  = 44;
    localparam int SETTLE       = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    logic [31:0]          mismatch_n;
    logic [31:0]          outstanding_n;
    logic [31:0]          results_n;

    bit                   cur_be;
    bit                   cur_dbl;
    logic [7:0]           frame_q[$];
    int                   bytes_sent;
    int                   frames_sent;
    int                   settings_run;
    int                   s_calm;
    int                   m_calm;
    int                   stall_cycles;

    binary_log_record_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    record_stream_checker stream_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatch_n),
        .outstanding  (outstanding_n),
        .results_seen (results_n)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle cycles before the next request, with calm stretches of none
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 24) == 0)
                calm = $urandom_range(8, 30);
            gap = $urandom_range(0, 17);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        bit took;
        draw_gap(s_calm, gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        bytes_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding_n != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input bit be, input bit cf, input bit dbl);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_BIG_ENDIAN;
        cfg_data  <= be;
        @(posedge clk);
        cfg_index <= CFG_COUNTED;
        cfg_data  <= cf;
        @(posedge clk);
        cfg_index <= CFG_DOUBLED;
        cfg_data  <= dbl;
        @(posedge clk);
        // an index with no register behind it must change nothing
        cfg_index <= CFG_SPARE;
        cfg_data  <= 1'($urandom_range(0, 1));
        @(posedge clk);
        cfg_wen <= 1'b0;
        cur_be  = be;
        cur_dbl = dbl;
        settings_run++;
    endtask

    task automatic push_word(input logic [31:0] w, input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            frame_q.push_back(cur_be ? 8'(w >> (8 * (nbytes - 1 - i))) : 8'(w >> (8 * i)));
    endtask

    task automatic add_record(input logic [1:0] sel, input logic [13:0] id,
                              input logic [31:0] stamp, input logic [15:0] cnt,
                              input int cap);
        int n;
        n = (sel == SEL_COUNTED) ? int'(id) : (cnt[15] ? int'(cnt[14:0]) : int'(cnt[15:8]));
        if (n > cap)
            n = cap;
        push_word({16'd0, sel, id}, 2);
        if (sel == SEL_STAMP16 && cur_dbl)
            push_word($urandom, 2);
        if (sel == SEL_STAMP16)
            push_word(stamp, 2);
        else if (sel == SEL_STAMP32)
            push_word(stamp, 4);
        if (sel != SEL_COUNTED)
            push_word({16'd0, cnt}, 2);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic add_padding();
        repeat ((ALIGN_DEF - frame_q.size() % ALIGN_DEF) % ALIGN_DEF)
            frame_q.push_back(8'd0);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
        frame_q.delete();
    endtask

    // mostly well-formed records with random content, some noise, some cut short
    task automatic random_frame();
        int          cut;
        int          pick;
        logic [1:0]  sel;
        logic [13:0] id;
        logic [15:0] cnt;
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                sel = 2'($urandom_range(0, 3));
                id  = (sel == SEL_COUNTED) ? 14'($urandom_range(0, 5)) : 14'($urandom);
                if ($urandom_range(0, 1) == 1)
                    cnt = {1'b1, 15'($urandom_range(0, 5))};
                else
                    cnt = {8'($urandom_range(0, 5)), 8'($urandom)};
                add_record(sel, id, $urandom, cnt, 6);
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    add_padding();
                else if (pick == 9)
                    frame_q.push_back(8'($urandom_range(1, 255)));
            end
            if ($urandom_range(0, 6) == 0 && frame_q.size() > 1)
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
        send_frame();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no request moved for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: random stalls per request
    initial
    begin
        int gap;
        bit took;
        m_tready = 1'b0;
        m_calm = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            draw_gap(m_calm, gap);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = m_tvalid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    initial
    begin
        int order[8];
        int i;
        int j;
        int tmp;
        int p;
        int phase_start;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = CFG_BIG_ENDIAN;
        cfg_data  = 1'b0;
        cur_be    = 1;
        cur_dbl   = 0;
        s_calm    = 0;
        bytes_sent = 0;
        frames_sent = 0;
        settings_run = 0;
        for (i = 0; i < 8; i++)
            order[i] = i;
        for (i = 7; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 32-bit stamp of all ones, short count form with full cycle field and no payload
        add_record(SEL_STAMP32, 14'h3fff, 32'hffff_ffff, 16'h00ff, 0);
        send_frame();
        // counted frames: zero padding eaten, then a non-zero pad byte on the last byte
        add_record(SEL_COUNTED, 14'd1, 32'd0, 16'd0, 1);
        add_padding();
        add_record(SEL_COUNTED, 14'd1, 32'd0, 16'd0, 1);
        frame_q.push_back(8'hc0);
        send_frame();
        // longest payload length, buffer ends after one payload byte
        add_record(SEL_STAMP16, 14'h2aaa, 32'h0000_ffff, 16'hffff, 1);
        send_frame();

        drain();
        write_cfg(0, 0, 1);
        // counted frame refused, rest of the buffer ignored
        add_record(SEL_COUNTED, 14'd2, 32'd0, 16'd0, 2);
        send_frame();
        // little endian 16-bit stamp behind a skipped word of random bytes
        add_record(SEL_STAMP16, 14'h1555, 32'h0000_a55a, 16'h8000, 0);
        send_frame();

        for (p = 0; p < 8; p++)
        begin
            drain();
            write_cfg(order[p][0], order[p][1], order[p][2]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
        end
        drain();

        $display("covered %0d bytes in %0d buffers under %0d register settings",
                 bytes_sent, frames_sent, settings_run);
        $display("%0d output requests compared with the prediction", results_n);
        if (mismatch_n == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/blrp_pkg.sv
design/blrp_ctrl.sv
design/blrp_datapath.sv
design/binary_log_record_parser.sv
bench/record_stream_checker.sv
bench/tb_top.sv
